// ===== hw/rtl/lpc_pkg.sv =====
package lpc_pkg;

  localparam int unsigned NumChan = 3;

  typedef enum logic [2:0] {
    LAYER_BACKDROP = 3'd0,
    LAYER_SPRITE   = 3'd1,
    LAYER_BG1      = 3'd2,
    LAYER_BG2      = 3'd3,
    LAYER_BG3      = 3'd4,
    LAYER_BG4      = 3'd5
  } layer_t;

  typedef enum logic [2:0] {
    CFG_BG_MODE      = 3'd0,
    CFG_THIRD_RAISED = 3'd1,
    CFG_MATH_SELECT  = 3'd2,
    CFG_MATH_CONTROL = 3'd3,
    CFG_FIXED_RED    = 3'd4,
    CFG_FIXED_GREEN  = 3'd5,
    CFG_FIXED_BLUE   = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] MODE0 = 3'd0;
  localparam logic [2:0] MODE1 = 3'd1;
  localparam logic [2:0] MODE3 = 3'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic [7:0] idx;
    layer_t     layer;
  } pick_t;

  function automatic logic lay_hit(input logic [8:0] pix, input logic pri);
    return (pix[7:0] != 8'd0) && (pix[8] == pri);
  endfunction

  function automatic logic spr_hit(input logic [7:0] si, input logic [1:0] sp,
                                   input logic [1:0] pri);
    return (si != 8'd0) && (sp == pri);
  endfunction

  function automatic pick_t pick_winner(
    input logic [2:0] mode,
    input logic       raised,
    input logic [8:0] b1,
    input logic [8:0] b2,
    input logic [8:0] b3,
    input logic [8:0] b4,
    input logic [7:0] si,
    input logic [1:0] sp
  );
    pick_t p;
    pick_t s;
    pick_t l1;
    pick_t l2;
    pick_t l3;
    pick_t l4;
    pick_t bd;
    s  = '{idx: si, layer: LAYER_SPRITE};
    l1 = '{idx: b1[7:0], layer: LAYER_BG1};
    l2 = '{idx: b2[7:0], layer: LAYER_BG2};
    l3 = '{idx: b3[7:0], layer: LAYER_BG3};
    l4 = '{idx: b4[7:0], layer: LAYER_BG4};
    bd = '{idx: 8'd0, layer: LAYER_BACKDROP};
    p  = bd;
    unique case (mode)
      MODE0: begin
        priority if (spr_hit(si, sp, 2'd3)) p = s;
        else if (lay_hit(b1, 1'b1)) p = l1;
        else if (lay_hit(b2, 1'b1)) p = l2;
        else if (spr_hit(si, sp, 2'd2)) p = s;
        else if (lay_hit(b3, 1'b1)) p = l3;
        else if (lay_hit(b4, 1'b1)) p = l4;
        else if (spr_hit(si, sp, 2'd1)) p = s;
        else if (lay_hit(b1, 1'b0)) p = l1;
        else if (lay_hit(b2, 1'b0)) p = l2;
        else if (spr_hit(si, sp, 2'd0)) p = s;
        else if (lay_hit(b3, 1'b0)) p = l3;
        else if (lay_hit(b4, 1'b0)) p = l4;
        else p = bd;
      end
      MODE1: begin
        if (raised) begin
          priority if (lay_hit(b3, 1'b1)) p = l3;
          else if (spr_hit(si, sp, 2'd3)) p = s;
          else if (lay_hit(b1, 1'b1)) p = l1;
          else if (lay_hit(b2, 1'b1)) p = l2;
          else if (spr_hit(si, sp, 2'd2)) p = s;
          else if (lay_hit(b1, 1'b0)) p = l1;
          else if (lay_hit(b2, 1'b0)) p = l2;
          else if (spr_hit(si, sp, 2'd1)) p = s;
          else if (lay_hit(b3, 1'b0)) p = l3;
          else if (spr_hit(si, sp, 2'd0)) p = s;
          else p = bd;
        end else begin
          priority if (spr_hit(si, sp, 2'd3)) p = s;
          else if (lay_hit(b1, 1'b1)) p = l1;
          else if (lay_hit(b2, 1'b1)) p = l2;
          else if (spr_hit(si, sp, 2'd2)) p = s;
          else if (lay_hit(b1, 1'b0)) p = l1;
          else if (lay_hit(b2, 1'b0)) p = l2;
          else if (spr_hit(si, sp, 2'd1)) p = s;
          else if (lay_hit(b3, 1'b1)) p = l3;
          else if (spr_hit(si, sp, 2'd0)) p = s;
          else if (lay_hit(b3, 1'b0)) p = l3;
          else p = bd;
        end
      end
      MODE3: begin
        priority if (spr_hit(si, sp, 2'd3)) p = s;
        else if (lay_hit(b1, 1'b1)) p = l1;
        else if (lay_hit(b2, 1'b1)) p = l2;
        else if (spr_hit(si, sp, 2'd2)) p = s;
        else if (lay_hit(b1, 1'b0)) p = l1;
        else if (lay_hit(b2, 1'b0)) p = l2;
        else if (spr_hit(si, sp, 2'd1)) p = s;
        else if (spr_hit(si, sp, 2'd0)) p = s;
        else p = bd;
      end
      default: p = bd;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/layer_priority_compositor.sv =====
// a pixel transaction accepted into stage a reaches the output through the stage b, c and d registers
// throughput: one transaction per cycle while result_stall is low, set by four register stages with per-stage hold
// (input/priority, palette read, color math add/sub, saturate/halve output)
// palette writes complete in the palette-read stage and produce no result
// reset clears config registers, stage valids and the palette valid bits;
// a palette entry reads as zero until it is written
module layer_priority_compositor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [7:0]  palette_index,
  input  logic [14:0] palette_color,
  input  logic [8:0]  bg1_pixel,
  input  logic [8:0]  bg2_pixel,
  input  logic [8:0]  bg3_pixel,
  input  logic [8:0]  bg4_pixel,
  input  logic [7:0]  sprite_index,
  input  logic [1:0]  sprite_priority,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [2:0]  winner_layer
);

  // config registers
  logic [2:0] bg_mode;
  logic       third_layer_raised;
  logic [7:0] math_select;
  logic [7:0] math_control;
  logic [lpc_pkg::NumChan-1:0][4:0] fixed_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_mode            <= '0;
      third_layer_raised <= 1'b0;
      math_select        <= '0;
      math_control       <= '0;
      fixed_color        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lpc_pkg::CFG_BG_MODE:      bg_mode            <= cfg_data[2:0];
        lpc_pkg::CFG_THIRD_RAISED: third_layer_raised <= cfg_data[0];
        lpc_pkg::CFG_MATH_SELECT:  math_select        <= cfg_data;
        lpc_pkg::CFG_MATH_CONTROL: math_control       <= cfg_data;
        lpc_pkg::CFG_FIXED_RED:    fixed_color[0]     <= cfg_data[4:0];
        lpc_pkg::CFG_FIXED_GREEN:  fixed_color[1]     <= cfg_data[4:0];
        lpc_pkg::CFG_FIXED_BLUE:   fixed_color[2]     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v_a, v_b, v_c;
  logic ready_a, ready_b, ready_c, ready_d;

  assign ready_d    = !result_valid || !result_stall;
  assign ready_c    = !v_c || ready_d;
  assign ready_b    = !v_b || ready_c;
  assign ready_a    = !v_a || ready_b;
  assign item_stall = !ready_a;

  // stage a: input register, winner pick
  logic        act_a;
  logic [7:0]  wr_idx_a;
  logic [14:0] wr_col_a;
  logic [8:0]  b1_a, b2_a, b3_a, b4_a;
  logic [7:0]  si_a;
  logic [1:0]  sp_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (ready_a) begin
      v_a <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      act_a    <= action;
      wr_idx_a <= palette_index;
      wr_col_a <= palette_color;
      b1_a     <= bg1_pixel;
      b2_a     <= bg2_pixel;
      b3_a     <= bg3_pixel;
      b4_a     <= bg4_pixel;
      si_a     <= sprite_index;
      sp_a     <= sprite_priority;
    end
  end

  lpc_pkg::pick_t pick_a;
  logic           math_en_a;

  always_comb begin
    pick_a    = lpc_pkg::pick_winner(bg_mode, third_layer_raised,
                                     b1_a, b2_a, b3_a, b4_a, si_a, sp_a);
    math_en_a = math_select[pick_a.layer] && (math_control[7:6] == 2'b00);
  end

  // stage b: palette access (writes retire here, reads registered)
  logic [14:0] palette [256];
  logic [255:0] pal_valid;
  logic        pal_wr, pal_rd;
  logic [14:0] rd_col_b;
  logic        rd_ok_b;
  lpc_pkg::layer_t layer_b;
  logic        math_en_b;

  assign pal_wr = v_a && ready_b && (act_a == lpc_pkg::ACT_WRITE);
  assign pal_rd = v_a && ready_b && (act_a == lpc_pkg::ACT_PIXEL);

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      palette[wr_idx_a] <= wr_col_a;
    end
    if (pal_rd) begin
      rd_col_b <= palette[pick_a.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
      rd_ok_b   <= 1'b0;
    end else begin
      if (pal_wr) begin
        pal_valid[wr_idx_a] <= 1'b1;
      end
      if (pal_rd) begin
        rd_ok_b <= pal_valid[pick_a.idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (ready_b) begin
      v_b <= v_a && (act_a == lpc_pkg::ACT_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (pal_rd) begin
      layer_b   <= pick_a.layer;
      math_en_b <= math_en_a;
    end
  end

  // stage b comb: expand to 8 bits, add or subtract fixed color
  logic [14:0] col_b;
  logic [lpc_pkg::NumChan-1:0][7:0] m_b;
  logic [lpc_pkg::NumChan-1:0][8:0] res_b;

  always_comb begin
    col_b = rd_ok_b ? rd_col_b : 15'd0;
    for (int i = 0; i < lpc_pkg::NumChan; i++) begin
      m_b[i] = {col_b[i*5 +: 5], 3'b000};
      if (math_select[7]) begin
        res_b[i] = {1'b0, m_b[i]} - {1'b0, fixed_color[i], 3'b000};
      end else begin
        res_b[i] = {1'b0, m_b[i]} + {1'b0, fixed_color[i], 3'b000};
      end
    end
  end

  // stage c
  logic [lpc_pkg::NumChan-1:0][7:0] m_c;
  logic [lpc_pkg::NumChan-1:0][8:0] res_c;
  lpc_pkg::layer_t layer_c;
  logic            math_en_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (ready_c) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && v_b) begin
      m_c       <= m_b;
      res_c     <= res_b;
      layer_c   <= layer_b;
      math_en_c <= math_en_b;
    end
  end

  // stage c comb: saturate or clamp, then optional halve
  logic [lpc_pkg::NumChan-1:0][7:0] chan_c;

  always_comb begin
    for (int i = 0; i < lpc_pkg::NumChan; i++) begin
      if (!math_en_c) begin
        chan_c[i] = m_c[i];
      end else begin
        // bit 8 is the borrow when subtracting, the carry when adding
        if (math_select[7]) begin
          chan_c[i] = res_c[i][8] ? 8'd0 : res_c[i][7:0];
        end else begin
          chan_c[i] = res_c[i][8] ? 8'hFF : res_c[i][7:0];
        end
        if (math_select[6]) begin
          chan_c[i] = {1'b0, chan_c[i][7:1]};
        end
      end
    end
  end

  // stage d: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready_d) begin
      result_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && v_c) begin
      red          <= chan_c[0];
      green        <= chan_c[1];
      blue         <= chan_c[2];
      winner_layer <= layer_c;
    end
  end

  // checks
  assert property (@(posedge clk) rst |=> (pal_valid == '0))
    else $error("palette valid bits not cleared by reset");

  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (v_a && v_b && v_c && result_valid))
    else $error("input stalled while a stage is empty");

  assert property (@(posedge clk) disable iff (rst)
    (v_c && ready_d) |=> result_valid)
    else $error("transaction lost between math stage and output");

  assert property (@(posedge clk) disable iff (rst)
    (v_a && ready_b && (act_a == lpc_pkg::ACT_WRITE)) |=> !($past(pal_rd)))
    else $error("palette read and write in the same cycle");

endmodule
